FILE: rtl/mh_pkg.sv
package mh_pkg;

  // multiplier of the mixing steps and the right shift of the shift-mix
  localparam logic [63:0] HASH_MUL  = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT = 47;

  // what the back end does with one queued word
  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,  // zero byte count, nothing mixed
    CLS_PART = 2'd1,  // one to seven bytes, xor then multiply
    CLS_FULL = 2'd2   // eight bytes, full word mix
  } word_cls_t;

  typedef struct packed {
    logic [63:0] word;      // masked data
    word_cls_t   cls;
    logic        first;
    logic        last;
    logic [31:0] length;
  } q_entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } mul_rsp_t;

  function automatic logic [63:0] shift_mix(input logic [63:0] x);
    shift_mix = x ^ (x >> MIX_SHIFT);
  endfunction

endpackage

FILE: rtl/mh_fifo.sv
module mh_fifo
  import mh_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output q_entry_t pop_entry,
  output logic     not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/mh_front.sv
module mh_front
  import mh_pkg::*;
(
  input  logic        in_valid,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_first_word,
  input  logic        in_last_word,
  input  logic [31:0] in_message_length,
  output logic        push,
  output q_entry_t    entry
);

  logic [63:0] masked;

  // keep byte i only when it lies below the byte count
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[8*i +: 8] = (in_byte_count[3] || (4'(i) < in_byte_count)) ?
                         in_data_word[8*i +: 8] : 8'h00;
    end
  end

  always_comb begin
    entry.word   = masked;
    entry.first  = in_first_word;
    entry.last   = in_last_word;
    entry.length = in_message_length;
    priority if (in_byte_count[3]) begin
      entry.cls = CLS_FULL;
    end else if (in_byte_count != 4'd0) begin
      entry.cls = CLS_PART;
    end else begin
      entry.cls = CLS_NONE;
    end
  end

  assign push = in_valid;

endmodule

FILE: rtl/mh_mul.sv
module mh_mul
  import mh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  // a * HASH_MUL mod 2^64 with one 32x32 multiplier over three steps
  logic [63:0] a_r;
  logic [63:0] acc_r;
  logic [1:0]  step_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] op_x;
  logic [31:0] op_y;
  logic [63:0] prod;

  always_comb begin
    unique case (step_r)
      2'd0: begin
        op_x = a_r[31:0];
        op_y = HASH_MUL[31:0];
      end
      2'd1: begin
        op_x = a_r[63:32];
        op_y = HASH_MUL[31:0];
      end
      default: begin
        op_x = a_r[31:0];
        op_y = HASH_MUL[63:32];
      end
    endcase
  end

  assign prod = op_x * op_y;

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.operand;
    end
    if (busy_r) begin
      if (step_r == 2'd0) begin
        acc_r <= prod;
      end else begin
        acc_r[63:32] <= acc_r[63:32] + prod[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

endmodule

FILE: rtl/mh_back.sv
module mh_back
  import mh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [63:0] seed,
  input  logic        q_not_empty,
  input  q_entry_t    q_entry,
  output logic        q_pop,
  output mul_req_t    mul_req,
  input  mul_rsp_t    mul_rsp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_INIT     = 8'b0000_0010,
    ST_DISPATCH = 8'b0000_0100,
    ST_MIX1     = 8'b0000_1000,
    ST_MIX2     = 8'b0001_0000,
    ST_MIX3     = 8'b0010_0000,
    ST_FIN      = 8'b0100_0000,
    ST_EMIT     = 8'b1000_0000
  } back_state_t;

  back_state_t state_r, state_nxt;
  q_entry_t    ent_r;
  logic [63:0] hash_r, hash_nxt;
  logic [63:0] fin_r;
  logic        fin_load;
  logic        out_valid_r;
  logic [63:0] out_hash_r;
  logic        out_load;

  always_comb begin
    state_nxt       = state_r;
    hash_nxt        = hash_r;
    q_pop           = 1'b0;
    mul_req.start   = 1'b0;
    mul_req.operand = '0;
    fin_load        = 1'b0;
    out_load        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          if (q_entry.first) begin
            mul_req.start   = 1'b1;
            mul_req.operand = {32'd0, q_entry.length};
            state_nxt       = ST_INIT;
          end else begin
            state_nxt = ST_DISPATCH;
          end
        end
      end
      ST_INIT: begin
        if (mul_rsp.done) begin
          hash_nxt  = seed ^ mul_rsp.result;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (ent_r.cls)
          CLS_FULL: begin
            mul_req.start   = 1'b1;
            mul_req.operand = ent_r.word;
            state_nxt       = ST_MIX1;
          end
          CLS_PART: begin
            mul_req.start   = 1'b1;
            mul_req.operand = hash_r ^ ent_r.word;
            state_nxt       = ST_MIX3;
          end
          default: begin
            if (ent_r.last) begin
              mul_req.start   = 1'b1;
              mul_req.operand = shift_mix(hash_r);
              state_nxt       = ST_FIN;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end
      ST_MIX1: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = shift_mix(mul_rsp.result);
          state_nxt       = ST_MIX2;
        end
      end
      ST_MIX2: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = hash_r ^ mul_rsp.result;
          state_nxt       = ST_MIX3;
        end
      end
      ST_MIX3: begin
        if (mul_rsp.done) begin
          hash_nxt = mul_rsp.result;
          if (ent_r.last) begin
            mul_req.start   = 1'b1;
            mul_req.operand = shift_mix(mul_rsp.result);
            state_nxt       = ST_FIN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (mul_rsp.done) begin
          fin_load  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_entry;
    end
    if (fin_load) begin
      fin_r <= shift_mix(mul_rsp.result);
    end
    if (out_load) begin
      out_hash_r <= fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hash_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hash_r  <= hash_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_hash  = out_hash_r;

endmodule

FILE: rtl/murmur64_seeded_hash_top.sv
// seeded 64-bit multiply-shift message hash, one 64-bit little-endian word per beat
// input channel: in_valid/in_ready with data word, byte count (0..8), first/last
//   flags and the total message length, which is sampled on the first beat only
// output channel: out_valid/out_ready carrying the finalized 64-bit hash, one beat
//   for every input beat flagged last
// config: apb-style write of the 64-bit seed at byte address 0; pready tied high
// the front end masks and classifies each beat into a small queue; the back end
//   walks it through one shared 32x32 multiplier, one 64-bit product at a time
// work per beat: one product for a first beat (the length), one for a partial word,
//   three for a full word and one for a last beat, plus the output handoff; a full
//   middle word takes the longest, set by the serial multiply chain
// after a last beat the hash passes the finalize product and fin_r, then out_hash_r
// reset (rst_n low, synchronous) clears the seed, the running hash, the queue and
//   the output valid flag; nothing is emitted until a last beat arrives
// a stalled receiver holds the result in the output register; the back end waits
//   with the next result while the queue keeps taking beats until it is full
module murmur64_seeded_hash_top
  import mh_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_first_word,
  input  logic        in_last_word,
  input  logic [31:0] in_message_length,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash,
  // config port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [63:0] seed_r;
  logic        push;
  q_entry_t    push_entry;
  logic        q_full;
  logic        q_pop;
  q_entry_t    q_entry;
  logic        q_not_empty;
  mul_req_t    mul_req;
  mul_rsp_t    mul_rsp;

  // seed register, the only one, at byte address 0 (bit 3 picks the 8-byte slot)
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[3] ? 64'd0 : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[3]) begin
      seed_r <= cfg_pwdata;
    end
  end

  // front end: byte masking and word classification
  mh_front u_front (
    .in_valid          (in_valid),
    .in_data_word      (in_data_word),
    .in_byte_count     (in_byte_count),
    .in_first_word     (in_first_word),
    .in_last_word      (in_last_word),
    .in_message_length (in_message_length),
    .push              (push),
    .entry             (push_entry)
  );

  // queue between the two halves
  mh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (q_entry),
    .not_empty  (q_not_empty)
  );

  assign in_ready = !q_full;

  // shared multiply-by-constant unit
  mh_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // back end: hash sequencer and output register
  mh_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .seed        (seed_r),
    .q_not_empty (q_not_empty),
    .q_entry     (q_entry),
    .q_pop       (q_pop),
    .mul_req     (mul_req),
    .mul_rsp     (mul_rsp),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_hash    (out_hash)
  );

endmodule
